// ----- rtl/aabb_pkg.sv -----
// Package: widths, request and result types, and event codes of the pair contact tracker.
package aabb_pkg;

    localparam int ID_BITS   = 6;
    localparam int IDX_BITS  = 2 * ID_BITS;
    localparam int DEPTH     = 1 << IDX_BITS;
    localparam int CRD_BITS  = 16;
    localparam int SIZE_BITS = 15;
    localparam int D_BITS    = CRD_BITS + 2;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_ENTER = 2'd1,
        EV_STAY  = 2'd2,
        EV_EXIT  = 2'd3
    } ev_t;

    typedef struct packed {
        logic [ID_BITS-1:0]          left_id;
        logic [ID_BITS-1:0]          right_id;
        logic signed [CRD_BITS-1:0]  left_center_x;
        logic signed [CRD_BITS-1:0]  left_center_y;
        logic [SIZE_BITS-1:0]        left_size_x;
        logic [SIZE_BITS-1:0]        left_size_y;
        logic signed [CRD_BITS-1:0]  right_center_x;
        logic signed [CRD_BITS-1:0]  right_center_y;
        logic [SIZE_BITS-1:0]        right_size_x;
        logic [SIZE_BITS-1:0]        right_size_y;
        logic                        left_dead;
        logic                        right_dead;
    } pair_t;

    typedef struct packed {
        ev_t  contact_event;
        logic overlapping;
        logic side_left;
        logic side_right;
        logic side_top;
        logic side_bottom;
    } contact_t;

endpackage

// ----- rtl/aabb_pair_contact_tracker.sv -----
// Pair contact tracker: box overlap test and enter/stay/exit events from a per-pair table.
// A request is registered into stage 1; its result is registered into the output register.
// Throughput: one request per cycle while the output is not stalled; the touch table is read at acceptance and
// written when the request leaves stage 1, with forwarding between back-to-back requests.
// Reset: all control state clears at once; then a clearing pass zeroes all 4096 entries
// of the touch table, one entry per cycle, with pair_ready held low.
module aabb_pair_contact_tracker
    import aabb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     pair_valid,
    output logic     pair_ready,
    input  pair_t    pair,
    output logic     contact_valid,
    input  logic     contact_ready,
    output contact_t contact
);

    logic                 mem [DEPTH];
    logic                 rdata_reg;

    logic                 clr_busy_reg;
    logic [IDX_BITS-1:0]  clr_addr_reg;

    logic                 s1_valid_reg;
    logic [IDX_BITS-1:0]  s1_idx_reg;
    logic                 s1_same_reg;
    logic                 s1_ldead_reg;
    logic                 s1_rdead_reg;
    logic [CRD_BITS-1:0]  s1_absx_reg;
    logic [CRD_BITS-1:0]  s1_absy_reg;
    logic [CRD_BITS-1:0]  s1_sumx_reg;
    logic [CRD_BITS-1:0]  s1_sumy_reg;
    logic                 s1_gtx_reg;
    logic                 s1_ltx_reg;
    logic                 s1_gty_reg;
    logic                 s1_lty_reg;

    logic                 fwd_hit_reg;
    logic                 fwd_data_reg;

    logic                 out_valid_reg;
    contact_t             out_reg;

    logic                 accept;
    logic                 advance;
    logic [IDX_BITS-1:0]  in_idx;
    logic signed [CRD_BITS:0] diffx;
    logic signed [CRD_BITS:0] diffy;
    logic [CRD_BITS-1:0]  absx;
    logic [CRD_BITS-1:0]  absy;
    logic [CRD_BITS-1:0]  sumx;
    logic [CRD_BITS-1:0]  sumy;

    logic signed [D_BITS-1:0] dx;
    logic signed [D_BITS-1:0] dy;
    logic                 ov;
    logic                 prev;
    contact_t             res;
    logic                 s1_we;
    logic                 s1_wdata;
    logic                 mem_we;
    logic [IDX_BITS-1:0]  mem_waddr;
    logic                 mem_wdata;

    // Request side: distances and size sums
    always_comb
    begin
        in_idx = {pair.left_id, pair.right_id};
        diffx  = {pair.left_center_x[CRD_BITS-1], pair.left_center_x}
               - {pair.right_center_x[CRD_BITS-1], pair.right_center_x};
        diffy  = {pair.left_center_y[CRD_BITS-1], pair.left_center_y}
               - {pair.right_center_y[CRD_BITS-1], pair.right_center_y};
        absx   = diffx[CRD_BITS] ? CRD_BITS'(-diffx) : diffx[CRD_BITS-1:0];
        absy   = diffy[CRD_BITS] ? CRD_BITS'(-diffy) : diffy[CRD_BITS-1:0];
        sumx   = {1'b0, pair.left_size_x} + {1'b0, pair.right_size_x};
        sumy   = {1'b0, pair.left_size_y} + {1'b0, pair.right_size_y};
    end

    // Stage 1: penetration depths, sides, event
    always_comb
    begin
        dx   = $signed({2'b00, s1_sumx_reg}) - $signed({1'b0, s1_absx_reg, 1'b0});
        dy   = $signed({2'b00, s1_sumy_reg}) - $signed({1'b0, s1_absy_reg, 1'b0});
        ov   = !dx[D_BITS-1] && !dy[D_BITS-1];
        prev = fwd_hit_reg ? fwd_data_reg : rdata_reg;

        res.overlapping = ov;
        res.side_left   = ov && (dx <= dy) && s1_gtx_reg;
        res.side_right  = ov && (dx <= dy) && s1_ltx_reg;
        res.side_top    = ov && (dx > dy) && s1_gty_reg;
        res.side_bottom = ov && (dx > dy) && s1_lty_reg;

        res.contact_event = EV_NONE;
        if (!s1_same_reg)
        begin
            if (ov)
            begin
                if (prev)
                    res.contact_event = (s1_ldead_reg || s1_rdead_reg) ? EV_EXIT : EV_STAY;
                else if (!(s1_ldead_reg && s1_rdead_reg))
                    res.contact_event = EV_ENTER;
            end
            else if (prev)
            begin
                res.contact_event = EV_EXIT;
            end
        end

        advance  = s1_valid_reg && (!out_valid_reg || contact_ready);
        s1_we    = advance && (res.contact_event == EV_ENTER || res.contact_event == EV_EXIT);
        s1_wdata = (res.contact_event == EV_ENTER);

        pair_ready = !clr_busy_reg && (!s1_valid_reg || advance);
        accept     = pair_valid && pair_ready;

        mem_we    = clr_busy_reg || s1_we;
        mem_waddr = clr_busy_reg ? clr_addr_reg : s1_idx_reg;
        mem_wdata = clr_busy_reg ? 1'b0 : s1_wdata;
    end

    // Touch table
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (accept)
            rdata_reg <= mem[in_idx];
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg   <= in_idx;
            s1_same_reg  <= (pair.left_id == pair.right_id);
            s1_ldead_reg <= pair.left_dead;
            s1_rdead_reg <= pair.right_dead;
            s1_absx_reg  <= absx;
            s1_absy_reg  <= absy;
            s1_sumx_reg  <= sumx;
            s1_sumy_reg  <= sumy;
            s1_gtx_reg   <= !diffx[CRD_BITS] && (diffx != '0);
            s1_ltx_reg   <= diffx[CRD_BITS];
            s1_gty_reg   <= !diffy[CRD_BITS] && (diffy != '0);
            s1_lty_reg   <= diffy[CRD_BITS];
            fwd_data_reg <= s1_wdata;
        end
        if (advance)
            out_reg <= res;
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == IDX_BITS'(DEPTH - 1))
                    clr_busy_reg <= 1'b0;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= s1_we && (s1_idx_reg == in_idx);
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (contact_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign contact_valid = out_valid_reg;
    assign contact       = out_reg;

    a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !pair_ready && !s1_valid_reg)
        else $error("request path active during table clear");

    a_stay_needs_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        contact_valid && contact.contact_event == EV_STAY |-> contact.overlapping)
        else $error("stay without overlap");

    a_sides_need_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        contact_valid && !contact.overlapping |->
            !(contact.side_left || contact.side_right || contact.side_top || contact.side_bottom))
        else $error("contact side without overlap");

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        contact_valid |-> $onehot0({contact.side_left, contact.side_right,
                                    contact.side_top, contact.side_bottom}))
        else $error("more than one contact side");

    a_enter_writes: assert property (@(posedge clk) disable iff (!rst_n)
        s1_we && !clr_busy_reg |=> out_valid_reg)
        else $error("table write without result");

endmodule

// ----- test/contact_check_pkg.sv -----
// Scoreboard for the pair contact tracker: predicts contact results and checks them in order.
package contact_check_pkg;

    import aabb_pkg::*;

    class contact_scoreboard;

        bit       touch_map[DEPTH];
        contact_t expected_q[$];
        int       failures;
        int       checked;
        int       overlap_count;
        int       event_count[4];

        function new();
            foreach (touch_map[i])
            begin
                touch_map[i] = 1'b0;
            end
            failures      = 0;
            checked       = 0;
            overlap_count = 0;
            foreach (event_count[i])
            begin
                event_count[i] = 0;
            end
        endfunction

        function contact_t predict_contact(pair_t req);
            int                  lcx, lcy, rcx, rcy;
            int                  lsx, lsy, rsx, rsy;
            int                  adx, ady, pen_x, pen_y;
            logic [IDX_BITS-1:0] idx;
            bit                  ov;
            bit                  was_touching;
            contact_t            c;
            lcx = req.left_center_x;
            lcy = req.left_center_y;
            rcx = req.right_center_x;
            rcy = req.right_center_y;
            lsx = req.left_size_x;
            lsy = req.left_size_y;
            rsx = req.right_size_x;
            rsy = req.right_size_y;
            adx = (lcx > rcx) ? lcx - rcx : rcx - lcx;
            ady = (lcy > rcy) ? lcy - rcy : rcy - lcy;
            pen_x = lsx + rsx - 2 * adx;
            pen_y = lsy + rsy - 2 * ady;
            ov = (pen_x >= 0) && (pen_y >= 0);
            c = '0;
            c.contact_event = EV_NONE;
            c.overlapping   = ov;
            if (ov)
            begin
                // side taken along the axis of smaller penetration, x on a tie
                if (pen_x > pen_y)
                begin
                    c.side_top    = lcy > rcy;
                    c.side_bottom = lcy < rcy;
                end
                else
                begin
                    c.side_left  = lcx > rcx;
                    c.side_right = lcx < rcx;
                end
            end
            if (req.left_id != req.right_id)
            begin
                idx = {req.left_id, req.right_id};
                was_touching = touch_map[idx];
                if (ov && was_touching)
                begin
                    if (req.left_dead || req.right_dead)
                    begin
                        c.contact_event = EV_EXIT;
                        touch_map[idx] = 1'b0;
                    end
                    else
                    begin
                        c.contact_event = EV_STAY;
                    end
                end
                else if (ov)
                begin
                    if (!(req.left_dead && req.right_dead))
                    begin
                        c.contact_event = EV_ENTER;
                        touch_map[idx] = 1'b1;
                    end
                end
                else if (was_touching)
                begin
                    c.contact_event = EV_EXIT;
                    touch_map[idx] = 1'b0;
                end
            end
            return c;
        endfunction

        function void note_request(pair_t req);
            expected_q.push_back(predict_contact(req));
        endfunction

        function void report(string what, int want, int got);
            failures++;
            if (failures <= 10)
            begin
                $display("result %0d: %s expected %0d got %0d", checked, what, want, got);
            end
        endfunction

        function void check_result(contact_t got);
            contact_t want;
            if (expected_q.size() == 0)
            begin
                report("unexpected result, contact word", 0, int'(got));
                return;
            end
            want = expected_q.pop_front();
            if (want.contact_event != got.contact_event)
            begin
                report("contact_event", int'(want.contact_event), int'(got.contact_event));
            end
            if (want.overlapping != got.overlapping)
            begin
                report("overlapping", want.overlapping, got.overlapping);
            end
            if (want.side_left != got.side_left)
            begin
                report("side_left", want.side_left, got.side_left);
            end
            if (want.side_right != got.side_right)
            begin
                report("side_right", want.side_right, got.side_right);
            end
            if (want.side_top != got.side_top)
            begin
                report("side_top", want.side_top, got.side_top);
            end
            if (want.side_bottom != got.side_bottom)
            begin
                report("side_bottom", want.side_bottom, got.side_bottom);
            end
            event_count[int'(want.contact_event)]++;
            if (want.overlapping)
            begin
                overlap_count++;
            end
            checked++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

    endclass

endpackage

// ----- test/tb_top.sv -----
// Testbench top: drives pair requests into the contact tracker and checks every contact result.
module tb_top;

    import aabb_pkg::*;
    import contact_check_pkg::*;

    localparam int RANDOM_PAIRS = 750;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     pair_valid;
    logic     pair_ready;
    pair_t    pair;
    logic     contact_valid;
    logic     contact_ready;
    contact_t contact;

    contact_scoreboard sb = new();
    int                sent = 0;

    aabb_pair_contact_tracker u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .pair_valid    (pair_valid),
        .pair_ready    (pair_ready),
        .pair          (pair),
        .contact_valid (contact_valid),
        .contact_ready (contact_ready),
        .contact       (contact)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic pair_t build_request(int lid, int rid, int lcx, int lcy, int lsx, int lsy,
                                            int rcx, int rcy, int rsx, int rsy, bit ld, bit rd);
        pair_t p;
        p.left_id        = ID_BITS'(lid);
        p.right_id       = ID_BITS'(rid);
        p.left_center_x  = CRD_BITS'(lcx);
        p.left_center_y  = CRD_BITS'(lcy);
        p.left_size_x    = SIZE_BITS'(lsx);
        p.left_size_y    = SIZE_BITS'(lsy);
        p.right_center_x = CRD_BITS'(rcx);
        p.right_center_y = CRD_BITS'(rcy);
        p.right_size_x   = SIZE_BITS'(rsx);
        p.right_size_y   = SIZE_BITS'(rsy);
        p.left_dead      = ld;
        p.right_dead     = rd;
        return p;
    endfunction

    // mostly nearby boxes on a small id pool so pairs repeat; the rest is full-range noise
    function automatic pair_t random_pair();
        int lcx, lcy, rcx, rcy;
        if ($urandom_range(0, 99) < 75)
        begin
            lcx = int'($urandom_range(0, 60000)) - 30000;
            lcy = int'($urandom_range(0, 60000)) - 30000;
            rcx = lcx + int'($urandom_range(0, 400)) - 200;
            rcy = lcy + int'($urandom_range(0, 400)) - 200;
            return build_request($urandom_range(0, 7), $urandom_range(0, 7), lcx, lcy,
                                 $urandom_range(0, 300), $urandom_range(0, 300), rcx, rcy,
                                 $urandom_range(0, 300), $urandom_range(0, 300),
                                 $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
        end
        return build_request($urandom_range(0, 63), $urandom_range(0, 63),
                             int'($urandom_range(0, 65535)) - 32768,
                             int'($urandom_range(0, 65535)) - 32768,
                             $urandom_range(0, 32767), $urandom_range(0, 32767),
                             int'($urandom_range(0, 65535)) - 32768,
                             int'($urandom_range(0, 65535)) - 32768,
                             $urandom_range(0, 32767), $urandom_range(0, 32767),
                             $urandom_range(0, 1), $urandom_range(0, 1));
    endfunction

    task automatic send_pair(input pair_t req, input int gap);
        if (gap > 0)
        begin
            pair_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pair       <= req;
        pair_valid <= 1'b1;
        @(posedge clk);
        while (!pair_ready) @(posedge clk);
        sb.note_request(req);
        sent++;
    endtask

    initial
    begin
        pair_t directed_q[$];
        rst_n      <= 1'b0;
        pair_valid <= 1'b0;
        pair       <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // enter, stay, exit, then idle on one pair
        directed_q.push_back(build_request(1, 2, 0, 0, 10, 10, 0, 0, 10, 10, 0, 0));
        directed_q.push_back(build_request(1, 2, 20, 0, 100, 100, 0, 0, 100, 100, 0, 0));
        directed_q.push_back(build_request(1, 2, 500, 0, 10, 10, 0, 0, 10, 10, 0, 0));
        directed_q.push_back(build_request(1, 2, 500, 0, 10, 10, 0, 0, 10, 10, 0, 0));
        // reversed order is its own pair; one dead box still enters
        directed_q.push_back(build_request(2, 1, 0, 0, 10, 10, 0, 0, 10, 10, 1, 0));
        directed_q.push_back(build_request(1, 2, 0, 0, 10, 10, 0, 0, 10, 10, 1, 1));
        directed_q.push_back(build_request(2, 1, 0, 0, 10, 10, 0, 0, 10, 10, 0, 1));
        // boxes just touching, then just apart
        directed_q.push_back(build_request(3, 4, 0, 0, 10, 10, 10, 0, 10, 10, 0, 0));
        directed_q.push_back(build_request(3, 4, 0, 0, 10, 10, 10, 0, 9, 10, 0, 0));
        // equal ids
        directed_q.push_back(build_request(5, 5, 3, -4, 50, 50, 0, 0, 50, 50, 0, 0));
        directed_q.push_back(build_request(63, 63, -1000, 1000, 5, 5, 1000, -1000, 5, 5, 1, 1));
        // coordinate and size extremes
        directed_q.push_back(build_request(0, 63, -32768, -32768, 32767, 32767,
                                           32767, 32767, 32767, 32767, 0, 0));
        directed_q.push_back(build_request(63, 0, -32768, -32768, 32767, 32767,
                                           -32768, -32768, 32767, 32767, 1, 1));
        directed_q.push_back(build_request(0, 63, 7, 7, 0, 0, 7, 7, 0, 0, 0, 0));
        directed_q.push_back(build_request(0, 63, 0, 0, 100, 100, 30, -10, 100, 100, 0, 0));
        directed_q.push_back(build_request(0, 63, 32767, 32767, 32767, 32767,
                                           32767, 32767, 32767, 32767, 0, 0));
        // contact on top, on bottom, then exit through a dead box and enter again
        directed_q.push_back(build_request(62, 61, 0, 50, 100, 100, 5, 0, 100, 100, 0, 0));
        directed_q.push_back(build_request(62, 61, 0, -50, 100, 100, -5, 0, 100, 100, 0, 0));
        directed_q.push_back(build_request(62, 61, 0, -50, 100, 100, -5, 0, 100, 100, 1, 0));
        directed_q.push_back(build_request(62, 61, 0, -50, 100, 100, -5, 0, 100, 100, 0, 0));

        foreach (directed_q[i])
        begin
            send_pair(directed_q[i], 0);
        end
        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            send_pair(random_pair(), (i % 100 < 25) ? 0 : $urandom_range(0, 8));
        end
        pair_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d pair requests and checked %0d contact results.", sent, sb.checked);
        $display("Events: %0d enter, %0d stay, %0d exit, %0d none; %0d overlapping.",
                 sb.event_count[EV_ENTER], sb.event_count[EV_STAY],
                 sb.event_count[EV_EXIT], sb.event_count[EV_NONE], sb.overlap_count);
        if (sb.failures == 0 && sb.pending() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    initial
    begin
        int gap;
        int taken;
        taken = 0;
        contact_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            // one long hold-off lets the tracker fill up and stall its input
            if (taken == 300)
            begin
                gap = 80;
            end
            else if (taken % 120 < 30)
            begin
                gap = 0;
            end
            else
            begin
                gap = $urandom_range(0, 8);
            end
            if (gap > 0)
            begin
                contact_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            contact_ready <= 1'b1;
            @(posedge clk);
            while (!contact_valid) @(posedge clk);
            sb.check_result(contact);
            taken++;
        end
    end

    initial
    begin
        #(20 * 250000);
        $display("Verification failed");
        $finish;
    end

endmodule
